FILE: hw/rtl/mjd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mjd_pkg;

  // Field widths fixed by the word formats
  localparam int unsigned JOB_W   = 6;
  localparam int unsigned LVL_W   = 2;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned SLICE_W = 8;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned CFG_IDX_W = 1;

  // Queue geometry, tied to the job and level field widths
  localparam int unsigned MAX_JOBS = 64;
  localparam int unsigned LEVELS   = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_JOB_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_SLICE = 1'b1;

  // Register reset values
  localparam logic [COUNT_W-1:0] JOB_COUNT_RST  = 7'd1;
  localparam logic [SLICE_W-1:0] TIME_SLICE_RST = 8'd4;

  // Command codes
  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  typedef struct packed {
    logic command;
    logic job_finished;
  } in_t;

  typedef struct packed {
    logic [JOB_W-1:0]   grant_job;
    logic [LVL_W-1:0]   grant_level;
    logic               first_run;
    logic [SLICE_W-1:0] slice_length;
    logic               all_done;
  } out_t;

  // Sequencer to datapath
  typedef struct packed {
    logic accept;   // take the input word
    logic update;   // start load or requeue
    logic grant;    // pick level, pop head, read queue memory
    logic load;     // write result register
  } ctrl_cmd_t;

  // Datapath to sequencer
  typedef struct packed {
    logic slot_free;
  } ctrl_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mlfq_job_dispatcher_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Four-level feedback-queue job dispatcher. A start word loads jobs
// 0..job_count-1 (at most MAX_JOBS) into the top level and returns the
// first grant; each report word drops the granted job if it finished, or
// requeues it one level down (the lowest level runs round robin), then
// returns the next grant from the highest non-empty level, or all_done when
// nothing is left. One word is in flight at a time and each passes through
// accept, queue update, level select with the registered queue memory read
// and result load; the next word is taken only after the result load. The
// result load waits while the previous result is still valid and out_ready
// is low. The top level is a job counter; the lower levels share one
// (LEVELS-1) x MAX_JOBS queue memory that needs no clearing after reset.
// Configuration must be written by the user only while the block is idle;
// the block itself does not enforce this.
module mlfq_job_dispatcher_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire mjd_pkg::in_t                  in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output mjd_pkg::out_t                      out_data,
  input  wire logic                          cfg_we,
  input  wire logic [mjd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mjd_pkg::CFG_W-1:0]     cfg_data
);

  mjd_pkg::ctrl_cmd_t  cmd;
  mjd_pkg::ctrl_stat_t stat;

  // Sequencer
  mjd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Queues, grant logic and result register
  mjd_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/mjd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mjd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire mjd_pkg::ctrl_stat_t stat,
  output mjd_pkg::ctrl_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_UPDATE = 4'b0010,
    S_GRANT  = 4'b0100,
    S_OUT    = 4'b1000
  } state_t;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_GRANT;
      end
      S_GRANT: begin
        cmd.grant  = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        // hold until the result register can take the word
        if (stat.slot_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mjd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module mjd_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire mjd_pkg::ctrl_cmd_t               cmd,
  output mjd_pkg::ctrl_stat_t                   stat,
  input  wire mjd_pkg::in_t                     in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output mjd_pkg::out_t                         out_data,
  input  wire logic                             cfg_we,
  input  wire logic [mjd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [mjd_pkg::CFG_W-1:0]        cfg_data
);

  localparam int unsigned MAX_JOBS = mjd_pkg::MAX_JOBS;
  localparam int unsigned LEVELS   = mjd_pkg::LEVELS;
  localparam int unsigned PW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned CW = $clog2(MAX_JOBS + 1);
  localparam int unsigned LW = $clog2(LEVELS);
  localparam int unsigned LL = LEVELS - 1;   // levels kept in queue memory
  localparam logic [PW-1:0] PTR_LAST = PW'(MAX_JOBS - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(MAX_JOBS);
  localparam logic [LW-1:0] LVL_TOP  = LW'(LEVELS - 1);

  // Configuration
  logic [mjd_pkg::COUNT_W-1:0] job_count;
  logic [mjd_pkg::SLICE_W-1:0] time_slice;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_count  <= mjd_pkg::JOB_COUNT_RST;
      time_slice <= mjd_pkg::TIME_SLICE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mjd_pkg::CFG_JOB_COUNT:  job_count  <= cfg_data[mjd_pkg::COUNT_W-1:0];
        mjd_pkg::CFG_TIME_SLICE: time_slice <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input word latch
  logic cmd_code;
  logic job_done;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_code <= in_data.command;
      job_done <= in_data.job_finished;
    end
  end

  // Top level: only ever filled by a start, in job order, so a counter pair
  logic [PW-1:0] top_job;
  logic [CW-1:0] top_count;

  // Lower levels: circular queues in memory
  logic [PW-1:0] heads  [LL];
  logic [PW-1:0] tails  [LL];
  logic [CW-1:0] counts [LL];
  logic [PW-1:0] qmem   [LL][MAX_JOBS];
  logic [PW-1:0] rd_job;

  // Schedule state
  logic [PW-1:0] current_job;
  logic [LW-1:0] current_level;
  logic          schedule_active;

  // Grant held between select and result load
  logic          g_top;
  logic          g_none;
  logic [LW-1:0] g_lvl;
  logic [PW-1:0] g_top_job;

  // Requeue target: next level down, level 0 stays put
  logic [LW-1:0] push_lvl;
  logic          push_en;

  assign push_lvl = (current_level != '0) ? current_level - 1'b1 : '0;
  assign push_en  = cmd.update && (cmd_code == mjd_pkg::CMD_REPORT) &&
                    schedule_active && !job_done && (counts[push_lvl] != CNT_FULL);

  // Highest non-empty lower level
  logic          sel_found;
  logic [LW-1:0] sel_lvl;

  always_comb begin
    sel_found = 1'b0;
    sel_lvl   = '0;
    for (int i = 0; i < LL; i++) begin
      if (counts[i] != '0) begin
        sel_found = 1'b1;
        sel_lvl   = LW'(i);
      end
    end
  end

  // Start load
  logic [CW-1:0] load_count;

  assign load_count = (int'(job_count) > MAX_JOBS) ? CNT_FULL : CW'(job_count);

  // Queue pointers and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      top_job   <= '0;
      top_count <= '0;
      for (int i = 0; i < LL; i++) begin
        heads[i]  <= '0;
        tails[i]  <= '0;
        counts[i] <= '0;
      end
    end else if (cmd.update && (cmd_code == mjd_pkg::CMD_START)) begin
      top_job   <= '0;
      top_count <= load_count;
      for (int i = 0; i < LL; i++) begin
        heads[i]  <= '0;
        tails[i]  <= '0;
        counts[i] <= '0;
      end
    end else if (push_en) begin
      tails[push_lvl]  <= (tails[push_lvl] == PTR_LAST) ? '0 : tails[push_lvl] + 1'b1;
      counts[push_lvl] <= counts[push_lvl] + 1'b1;
    end else if (cmd.grant) begin
      if (top_count != '0) begin
        top_job   <= top_job + 1'b1;
        top_count <= top_count - 1'b1;
      end else if (sel_found) begin
        heads[sel_lvl]  <= (heads[sel_lvl] == PTR_LAST) ? '0 : heads[sel_lvl] + 1'b1;
        counts[sel_lvl] <= counts[sel_lvl] - 1'b1;
      end
    end
  end

  // Queue memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (push_en) begin
      qmem[push_lvl][tails[push_lvl]] <= current_job;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.grant && (top_count == '0) && sel_found) begin
      rd_job <= qmem[sel_lvl][heads[sel_lvl]];
    end
  end

  // Grant decision
  always_ff @(posedge clk) begin
    if (cmd.grant) begin
      g_top     <= (top_count != '0);
      g_none    <= (top_count == '0) && !sel_found;
      g_lvl     <= (top_count != '0) ? LVL_TOP : sel_lvl;
      g_top_job <= top_job;
    end
  end

  // Result and schedule state
  logic [PW-1:0] g_job;
  assign g_job = g_top ? g_top_job : rd_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_job     <= '0;
      current_level   <= '0;
      schedule_active <= 1'b0;
    end else if (cmd.load) begin
      schedule_active <= !g_none;
      if (!g_none) begin
        current_job   <= g_job;
        current_level <= g_lvl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (g_none) begin
        out_data.grant_job    <= '0;
        out_data.grant_level  <= '0;
        out_data.first_run    <= 1'b0;
        out_data.slice_length <= '0;
        out_data.all_done     <= 1'b1;
      end else begin
        out_data.grant_job    <= mjd_pkg::JOB_W'(g_job);
        out_data.grant_level  <= mjd_pkg::LVL_W'(g_lvl);
        out_data.first_run    <= g_top;
        out_data.slice_length <= (time_slice == '0) ? mjd_pkg::SLICE_W'(1) : time_slice;
        out_data.all_done     <= 1'b0;
      end
    end
  end

  assign stat.slot_free = !out_valid || out_ready;

endmodule

`default_nettype wire
